@@ design/aqw_pkg.sv @@
package aqw_pkg;

  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned NodeW    = 32;
  localparam int unsigned WeightW  = 48;
  localparam int unsigned DivW     = 64;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  localparam logic signed [WeightW-1:0] WMax = {1'b0, {(WeightW-1){1'b1}}};
  localparam logic signed [WeightW-1:0] WMin = {1'b1, {(WeightW-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_LEFT   = 2'd1,
    PH_MIDDLE = 2'd2
  } phase_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_DIVL  = 7'b0000100,
    ST_MULR  = 7'b0001000,
    ST_DIVR  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  typedef struct packed {
    logic signed [WeightW-1:0] weight;
    logic [IdxW-1:0]           index;
    logic                      last;
  } result_t;

  function automatic logic [IdxW-1:0] next_index(input logic [IdxW-1:0] i);
    next_index = i + IdxW'(1);
  endfunction

  function automatic logic signed [WeightW-1:0] sat48(input logic signed [65:0] w);
    if (w > 66'(signed'(WMax))) sat48 = WMax;
    else if (w < 66'(signed'(WMin))) sat48 = WMin;
    else sat48 = w[WeightW-1:0];
  endfunction

endpackage

@@ design/aqw_stream_if.sv @@
interface aqw_node_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      node_value;
  logic                    is_last;
  modport source (output valid, node_value, is_last, input ready);
  modport sink (input valid, node_value, is_last, output ready);
  modport monitor (input valid, ready, node_value, is_last);
endinterface

interface aqw_weight_if;
  logic                    valid;
  logic                    ready;
  logic signed [47:0]      weight;
  logic [11:0]             weight_index;
  logic                    last_weight;
  modport source (output valid, weight, weight_index, last_weight, input ready);
  modport sink (input valid, weight, weight_index, last_weight, output ready);
  modport monitor (input valid, ready, weight, weight_index, last_weight);
endinterface

@@ design/aqw_divider.sv @@
// Restoring divider, one quotient bit per cycle. Divisor zero gives zero.
// The high word of the dividend is preloaded into the remainder, so the
// quotient must fit in the low word.
module aqw_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2*aqw_pkg::DivW-1:0]    dividend_i,
  input  logic [aqw_pkg::DivW-1:0]      divisor_i,
  output logic                          done_o,
  output logic [aqw_pkg::DivW-1:0]      quotient_o
);
  localparam int unsigned W = aqw_pkg::DivW;

  logic [2*W-1:0]                 num_q, num_d;
  logic [W:0]                     rem_q, rem_d;
  logic [W-1:0]                   den_q, den_d;
  logic [aqw_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic [W:0]                     shifted;
  logic [W:0]                     diff;

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[W-1:0], num_q[2*W-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      num_d  = {dividend_i[W-1:0], {W{1'b0}}};
      den_d  = divisor_i;
      rem_d  = {1'b0, dividend_i[2*W-1:W]};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Quotient bits shift into the low end of the numerator register.
      if (!diff[W]) begin
        rem_d = diff;
        num_d = {num_q[2*W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[2*W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == aqw_pkg::DivCntW'(W) - 1'b1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = busy_q && (cnt_q == aqw_pkg::DivCntW'(W) - 1'b1);
  assign quotient_o = den_q == '0 ? '0 : num_d[W-1:0];
endmodule

@@ design/adaptive_quadrature_weights.sv @@
// Channel   Dir  Payload
// node_in   in   node_value[31:0] signed, is_last
// wt_out    out  weight[47:0] signed, weight_index[11:0], last_weight
//
// A node that takes a Simpson panel needs two divisions on one shared divider,
// each with the high word preloaded, before its weights are emitted. Other nodes
// need no division.
// rst_ni clears the scan phase, index and state machine asynchronously.
// Up to three weights are queued; a stalled output holds the block busy.
module adaptive_quadrature_weights (
  input  logic         clk_i,
  input  logic         rst_ni,
  aqw_node_if.sink     node_in,
  aqw_weight_if.source wt_out
);
  localparam int unsigned W = aqw_pkg::DivW;

  aqw_pkg::state_e state_q;
  aqw_pkg::phase_e phase_q;
  logic signed [32:0] left_q, mid_q;
  logic signed [49:0] cw0_q, cw1_q;
  logic [aqw_pkg::IdxW-1:0] cnt_q;

  aqw_pkg::result_t res_q [3];
  logic [1:0] nres_q, rptr_q;

  logic signed [32:0] x_q;
  logic last_q;
  logic [33:0] a1_q, a2_q;
  logic [34:0] s_q;
  logic neg_q;
  logic [2*W-1:0] prod_q;
  logic [W-1:0] wl_q;

  logic div_done;
  logic [W-1:0] div_den, div_quo;

  logic signed [32:0] xin, h1, h2;
  logic [33:0] a1, a2;
  logic panel;

  assign xin = 33'(node_in.node_value);
  assign h1  = mid_q - left_q;
  assign h2  = xin - mid_q;
  assign a1  = h1[32] ? 34'(-h1) : 34'(h1);
  assign a2  = h2[32] ? 34'(-h2) : 34'(h2);
  assign panel = (h1 != 0) && (h2 != 0) && (h1[32] == h2[32]) &&
                 ({1'b0, a2} <= {a1, 1'b0}) && ({1'b0, a1} <= {a2, 1'b0});

  assign node_in.ready = (state_q == aqw_pkg::ST_IDLE);
  assign wt_out.valid  = (state_q == aqw_pkg::ST_EMIT);
  assign wt_out.weight       = res_q[rptr_q].weight;
  assign wt_out.weight_index = res_q[rptr_q].index;
  assign wt_out.last_weight  = res_q[rptr_q].last;

  always_comb begin
    div_den = '0;
    case (state_q)
      aqw_pkg::ST_DIVL: begin
        div_den = W'(a1_q) * W'(6);
      end
      aqw_pkg::ST_DIVR: begin
        div_den = W'(a2_q) * W'(6);
      end
      default: ;
    endcase
  end

  logic divl_go, divr_go, started_q;
  assign divl_go = (state_q == aqw_pkg::ST_DIVL) && !started_q;
  assign divr_go = (state_q == aqw_pkg::ST_DIVR) && !started_q;

  aqw_divider u_div (
    .clk_i, .rst_ni,
    .start_i(divl_go || divr_go),
    .dividend_i(prod_q),
    .divisor_i(div_den),
    .done_o(div_done),
    .quotient_o(div_quo)
  );

  // Multiply operands: s (35 bits) by (2*a - b) (at most 35 bits).
  logic [34:0] mop;
  always_comb begin
    if (state_q == aqw_pkg::ST_MUL) mop = 35'({a1_q, 1'b0} - {1'b0, a2_q});
    else mop = 35'({a2_q, 1'b0} - {1'b0, a1_q});
  end

  logic signed [65:0] wl_s, wr_s, wm_s;
  always_comb begin
    wl_s = 66'(wl_q);
    wr_s = 66'(div_quo);
    wm_s = 66'(s_q) - wl_s - wr_s;
    if (neg_q) begin
      wl_s = -wl_s; wr_s = -wr_s; wm_s = -wm_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aqw_pkg::ST_IDLE;
      phase_q   <= aqw_pkg::PH_FIRST;
      cnt_q     <= '0;
      nres_q    <= '0;
      rptr_q    <= '0;
      started_q <= 1'b0;
      left_q <= '0; mid_q <= '0; cw0_q <= '0; cw1_q <= '0;
      res_q  <= '{default: '0};
      x_q <= '0; last_q <= 1'b0; a1_q <= '0; a2_q <= '0; s_q <= '0;
      neg_q <= 1'b0; prod_q <= '0; wl_q <= '0;
    end else begin
      case (state_q)
        aqw_pkg::ST_IDLE: begin
          if (node_in.valid) begin
            x_q <= xin; last_q <= node_in.is_last;
            rptr_q <= '0;
            case (phase_q)
              aqw_pkg::PH_LEFT: begin
                if (node_in.is_last) begin
                  res_q[0] <= '{aqw_pkg::sat48(66'(cw0_q) + 66'((xin - left_q) / 2)),
                                cnt_q, 1'b0};
                  res_q[1] <= '{aqw_pkg::sat48(66'((xin - left_q) / 2)),
                                aqw_pkg::next_index(cnt_q), 1'b1};
                  nres_q <= 2'd2; phase_q <= aqw_pkg::PH_FIRST;
                  state_q <= aqw_pkg::ST_EMIT;
                end else begin
                  mid_q <= xin; cw1_q <= '0; phase_q <= aqw_pkg::PH_MIDDLE;
                end
              end
              aqw_pkg::PH_MIDDLE: begin
                if (panel) begin
                  a1_q <= a1; a2_q <= a2; s_q <= 35'(a1) + 35'(a2);
                  neg_q <= h1[32];
                  state_q <= aqw_pkg::ST_MUL;
                end else begin
                  res_q[0] <= '{aqw_pkg::sat48(66'(cw0_q) + 66'(h1 / 2)), cnt_q, 1'b0};
                  left_q <= mid_q;
                  cw0_q  <= cw1_q + 50'(h1 / 2);
                  cnt_q  <= aqw_pkg::next_index(cnt_q);
                  if (node_in.is_last) begin
                    res_q[1] <= '{aqw_pkg::sat48(66'(cw1_q) + 66'(h1 / 2) + 66'(h2 / 2)),
                                  aqw_pkg::next_index(cnt_q), 1'b0};
                    res_q[2] <= '{aqw_pkg::sat48(66'(h2 / 2)),
                                  aqw_pkg::next_index(aqw_pkg::next_index(cnt_q)), 1'b1};
                    nres_q <= 2'd3; phase_q <= aqw_pkg::PH_FIRST;
                  end else begin
                    mid_q <= xin; cw1_q <= '0; nres_q <= 2'd1;
                  end
                  state_q <= aqw_pkg::ST_EMIT;
                end
              end
              default: begin
                cnt_q <= '0;
                if (node_in.is_last) begin
                  res_q[0] <= '{'0, '0, 1'b1};
                  nres_q <= 2'd1; phase_q <= aqw_pkg::PH_FIRST;
                  state_q <= aqw_pkg::ST_EMIT;
                end else begin
                  left_q <= xin; cw0_q <= '0; cw1_q <= '0;
                  phase_q <= aqw_pkg::PH_LEFT;
                end
              end
            endcase
          end
        end
        aqw_pkg::ST_MUL: begin
          prod_q <= (2*W)'(70'(s_q) * 70'(mop));
          state_q <= aqw_pkg::ST_DIVL;
        end
        aqw_pkg::ST_DIVL: begin
          started_q <= 1'b1;
          if (div_done) begin
            wl_q <= div_quo; started_q <= 1'b0; state_q <= aqw_pkg::ST_MULR;
          end
        end
        aqw_pkg::ST_MULR: begin
          prod_q <= (2*W)'(70'(s_q) * 70'(mop));
          state_q <= aqw_pkg::ST_DIVR;
        end
        aqw_pkg::ST_DIVR: begin
          started_q <= 1'b1;
          if (div_done) begin
            started_q <= 1'b0;
            res_q[0] <= '{aqw_pkg::sat48(66'(cw0_q) + wl_s), cnt_q, 1'b0};
            res_q[1] <= '{aqw_pkg::sat48(66'(cw1_q) + wm_s), aqw_pkg::next_index(cnt_q),
                          1'b0};
            cnt_q <= aqw_pkg::next_index(aqw_pkg::next_index(cnt_q));
            if (last_q) begin
              res_q[2] <= '{aqw_pkg::sat48(wr_s),
                            aqw_pkg::next_index(aqw_pkg::next_index(cnt_q)), 1'b1};
              nres_q <= 2'd3; phase_q <= aqw_pkg::PH_FIRST;
            end else begin
              left_q <= x_q; cw0_q <= 50'(wr_s); nres_q <= 2'd2;
              phase_q <= aqw_pkg::PH_LEFT;
            end
            state_q <= aqw_pkg::ST_EMIT;
          end
        end
        aqw_pkg::ST_EMIT: begin
          if (wt_out.ready) begin
            rptr_q <= rptr_q + 1'b1;
            if (rptr_q + 2'd1 == nres_q) state_q <= aqw_pkg::ST_IDLE;
          end
        end
        default: state_q <= aqw_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/aqw_checker.sv @@
module aqw_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [47:0] weight
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while emitting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(weight)) else $error("unstable");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready || !out_valid) else $error("busy");
endmodule

bind adaptive_quadrature_weights aqw_sva u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(node_in.valid), .in_ready(node_in.ready),
  .out_valid(wt_out.valid), .out_ready(wt_out.ready),
  .weight(wt_out.weight)
);

@@ bench/aqw_checker.sv @@
`timescale 1ns / 1ps
module aqw_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  aqw_node_if.monitor   node_mon,
  aqw_weight_if.monitor wt_mon,
  output int            errors_o,
  output int            pending_o
);
  // Quadrature state kept beside the block.
  aqw_pkg::phase_e               scan_ph;
  logic signed [65:0]            left_x, mid_x;
  logic signed [65:0]            carry_l, carry_m;
  logic [aqw_pkg::IdxW-1:0]      left_idx;
  aqw_pkg::result_t              weights_due[$];

  function automatic logic signed [65:0] half_toward_zero(input logic signed [65:0] h);
    half_toward_zero = h / 2;
  endfunction

  task automatic push_weight(input logic signed [65:0] w,
                             input logic [aqw_pkg::IdxW-1:0] idx, input logic lst);
    aqw_pkg::result_t r;
    r.weight = aqw_pkg::sat48(w);
    r.index  = idx;
    r.last   = lst;
    weights_due.push_back(r);
  endtask

  task automatic predict_weights(input logic signed [31:0] xv, input logic lst);
    logic signed [65:0] x, h1, h2, a1, a2, s, wl, wr, wm, hf, hf2;
    logic [aqw_pkg::IdxW-1:0] mi;
    logic [131:0]       num;
    x = 66'(xv);
    if (scan_ph == aqw_pkg::PH_LEFT) begin
      if (lst) begin
        hf = half_toward_zero(x - left_x);
        push_weight(carry_l + hf, left_idx, 1'b0);
        push_weight(hf, left_idx + 1'b1, 1'b1);
        scan_ph = aqw_pkg::PH_FIRST;
      end else begin
        mid_x = x;
        carry_m = 0;
        scan_ph = aqw_pkg::PH_MIDDLE;
      end
    end else if (scan_ph == aqw_pkg::PH_MIDDLE) begin
      h1 = mid_x - left_x;
      h2 = x - mid_x;
      mi = left_idx + 1'b1;
      a1 = h1 < 0 ? -h1 : h1;
      a2 = h2 < 0 ? -h2 : h2;
      if (h1 != 0 && h2 != 0 && ((h1 < 0) == (h2 < 0)) && a2 <= 2 * a1 && a1 <= 2 * a2) begin
        s = a1 + a2;
        num = 132'(s) * 132'(2 * a1 - a2);
        wl = 66'(num / 132'(6 * a1));
        num = 132'(s) * 132'(2 * a2 - a1);
        wr = 66'(num / 132'(6 * a2));
        wm = s - wl - wr;
        if (h1 < 0) begin
          wl = -wl; wr = -wr; wm = -wm;
        end
        push_weight(carry_l + wl, left_idx, 1'b0);
        push_weight(carry_m + wm, mi, 1'b0);
        left_idx = mi + 1'b1;
        if (lst) begin
          push_weight(wr, left_idx, 1'b1);
          scan_ph = aqw_pkg::PH_FIRST;
        end else begin
          left_x = x;
          carry_l = wr;
          scan_ph = aqw_pkg::PH_LEFT;
        end
      end else begin
        hf = half_toward_zero(h1);
        push_weight(carry_l + hf, left_idx, 1'b0);
        left_x = mid_x;
        carry_l = carry_m + hf;
        left_idx = mi;
        if (lst) begin
          hf2 = half_toward_zero(h2);
          push_weight(carry_l + hf2, left_idx, 1'b0);
          push_weight(hf2, left_idx + 1'b1, 1'b1);
          scan_ph = aqw_pkg::PH_FIRST;
        end else begin
          mid_x = x;
          carry_m = 0;
          scan_ph = aqw_pkg::PH_MIDDLE;
        end
      end
    end else begin
      left_idx = '0;
      if (lst) begin
        push_weight(0, '0, 1'b1);
        scan_ph = aqw_pkg::PH_FIRST;
      end else begin
        left_x = x;
        carry_l = 0;
        carry_m = 0;
        scan_ph = aqw_pkg::PH_LEFT;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    aqw_pkg::result_t exp_w;
    if (!rst_ni) begin
      scan_ph  = aqw_pkg::PH_FIRST;
      left_x   = 0;
      mid_x    = 0;
      carry_l  = 0;
      carry_m  = 0;
      left_idx = '0;
      errors_o = 0;
      weights_due.delete();
    end else begin
      if (wt_mon.valid && wt_mon.ready) begin
        if (weights_due.size() == 0) begin
          $display("%0t: unexpected weight %0d idx %0d last %0b", $time, wt_mon.weight,
                   wt_mon.weight_index, wt_mon.last_weight);
          errors_o++;
        end else begin
          exp_w = weights_due.pop_front();
          if (exp_w.weight !== wt_mon.weight || exp_w.index !== wt_mon.weight_index ||
              exp_w.last !== wt_mon.last_weight) begin
            $display("%0t: expected weight %0d idx %0d last %0b, got %0d idx %0d last %0b",
                     $time, exp_w.weight, exp_w.index, exp_w.last, wt_mon.weight,
                     wt_mon.weight_index, wt_mon.last_weight);
            errors_o++;
          end
        end
      end
      if (node_mon.valid && node_mon.ready)
        predict_weights(node_mon.node_value, node_mon.is_last);
    end
    pending_o = weights_due.size();
  end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   stall_phase;

  aqw_node_if   node_in ();
  aqw_weight_if wt_out ();

  adaptive_quadrature_weights DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .node_in(node_in.sink),
    .wt_out (wt_out.source)
  );

  aqw_checker checker_inst (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .node_mon (node_in.monitor),
    .wt_mon   (wt_out.monitor),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL adaptive_quadrature_weights");
    $finish;
  end

  // Receiver stalls follow a rotating pattern with random stalls between, broken by long always-ready stretches.
  initial begin
    wt_out.ready = 1'b0;
    stall_phase = 0;
    forever begin
      @(posedge clk_i);
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) wt_out.ready <= 1'b1;
      else if (stall_phase % 7 < 3) wt_out.ready <= 1'b0;
      else wt_out.ready <= ($urandom_range(0, 4) != 0);
    end
  end

  task automatic send_node(input logic signed [31:0] v, input logic lst);
    node_in.valid      <= 1'b1;
    node_in.node_value <= v;
    node_in.is_last    <= lst;
    do @(posedge clk_i); while (!node_in.ready);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
    if (n > 0) begin
      node_in.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // One set: mostly near-uniform spacing so panels are taken, some wild steps.
  task automatic send_set(input int len);
    logic signed [31:0] x;
    int step, k;
    x = $urandom;
    step = $urandom_range(1, 1 << $urandom_range(0, 20));
    for (k = 0; k < len; k++) begin
      send_node(x, k == len - 1);
      idle_gap();
      case ($urandom_range(0, 9))
        0: x = $urandom;
        1: x = x;
        2: x = x - step;
        default: x = x + step + $signed($urandom_range(0, step)) - step / 3;
      endcase
    end
  endtask

  initial begin
    int sent;
    node_in.valid      <= 1'b0;
    node_in.node_value <= '0;
    node_in.is_last    <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: single-node set, extremes, equal nodes, reversed, panel edges.
    send_node(32'sh7FFF_FFFF, 1'b1);
    send_node(32'sh8000_0000, 1'b0);
    send_node(32'sh7FFF_FFFF, 1'b1);
    send_node(32'sd100, 1'b0);
    send_node(32'sd100, 1'b0);
    send_node(32'sd100, 1'b0);
    send_node(32'sd100, 1'b1);
    send_node(32'sd0, 1'b0);
    send_node(32'sd10, 1'b0);
    send_node(32'sd30, 1'b0);
    send_node(32'sd35, 1'b0);
    send_node(32'sd25, 1'b0);
    send_node(32'sd15, 1'b1);
    send_node(32'sh7FFF_FFFF, 1'b0);
    send_node(32'sd0, 1'b0);
    send_node(32'sh8000_0000, 1'b0);
    send_node(32'sh4000_0000, 1'b0);
    send_node(-32'sh4000_0000, 1'b1);
    send_node(32'sh8000_0000, 1'b0);
    send_node(32'sd0, 1'b0);
    send_node(32'sh7FFF_FFFF, 1'b1);
    sent = 21;
    while (sent < 320) begin
      int len;
      len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 30);
      send_set(len);
      sent += len;
    end
    node_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("PASS adaptive_quadrature_weights");
    else $display("FAIL adaptive_quadrature_weights");
    $finish;
  end
endmodule
